FILE: rtl/fecp_pkg.sv
// Shared types and constants of the flash erase command planner.
package fecp_pkg;

	// Default size of the flash address space and of one request
	localparam int ADDRESS_BITS_DEFAULT = 24;
	localparam int MAX_SECTORS_DEFAULT = 64;

	// Fixed port widths
	localparam int START_ADDR_W = 24;
	localparam int ERASE_BYTES_W = 19;
	localparam int OUT_ADDR_W = 24;

	// One sector is 4 KiB
	localparam int SECTOR_SHIFT = 12;
	localparam int BLOCK_SECTORS = 16;
	localparam int HALF_SECTORS = 8;

	// Sector counts: the front sees up to 128, a planned run holds up to 64
	localparam int FRONT_COUNT_W = 8;
	localparam int COUNT_W = 7;

	// Requests buffered between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_SECTOR = 2'd0,
		KIND_HALF = 2'd1,
		KIND_BLOCK = 2'd2
	} erase_kind_t;

	// Classification of one request passed to the back end
	typedef struct packed {
		logic err;
		logic [COUNT_W-1:0] sectors;
	} plan_ctl_t;

endpackage

FILE: rtl/flash_erase_command_planner.sv
// Top level of the flash erase command planner.
//
// A request (start_address, erase_bytes) is taken at a rising edge with start
// high and busy low. The front end rounds the count up to 4 KiB sectors, drops
// empty requests and flags requests above MAX_SECTORS_PER_REQUEST sectors; it
// then queues the request in a two-entry queue, and busy is high only while
// that queue is full. The back end loads a request from the queue and then
// issues one erase command per cycle (64 KiB, 32 KiB or 4 KiB erase) until
// the run ends; an oversize request gives its single error result. Each result
// is shown for exactly one cycle with result_strobe high and cannot be stalled;
// the last result of a request has last_command set. No clearing pass after
// reset.
module flash_erase_command_planner
	import fecp_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
	parameter int MAX_SECTORS_PER_REQUEST = MAX_SECTORS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [START_ADDR_W-1:0] start_address,
	input  logic [ERASE_BYTES_W-1:0] erase_bytes,
	output logic result_strobe,
	output logic [1:0] erase_kind,
	output logic [OUT_ADDR_W-1:0] erase_address,
	output logic request_error,
	output logic last_command
);

	localparam int ENTRY_W = $bits(plan_ctl_t) + ADDRESS_BITS;

	logic push;
	plan_ctl_t push_ctl;
	logic [ADDRESS_BITS-1:0] push_addr;
	logic pop;
	logic head_valid;
	logic [ENTRY_W-1:0] head_data;
	plan_ctl_t head_ctl;
	logic [ADDRESS_BITS-1:0] head_addr;

	fecp_front #(
		.ADDRESS_BITS(ADDRESS_BITS),
		.MAX_SECTORS_PER_REQUEST(MAX_SECTORS_PER_REQUEST)
	) u_front (
		.start(start),
		.full(busy),
		.start_address(start_address),
		.erase_bytes(erase_bytes),
		.push(push),
		.push_ctl(push_ctl),
		.push_addr(push_addr)
	);

	fecp_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_ctl, push_addr}),
		.pop(pop),
		.head_data(head_data),
		.not_empty(head_valid),
		.full(busy)
	);

	assign head_ctl = head_data[ENTRY_W-1:ADDRESS_BITS];
	assign head_addr = head_data[ADDRESS_BITS-1:0];

	fecp_back #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_ctl(head_ctl),
		.head_addr(head_addr),
		.pop(pop),
		.result_strobe(result_strobe),
		.erase_kind(erase_kind),
		.erase_address(erase_address),
		.request_error(request_error),
		.last_command(last_command)
	);

endmodule

FILE: rtl/fecp_front.sv
// Front end: accept a request, round it to sectors and classify it.
module fecp_front
	import fecp_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT,
	parameter int MAX_SECTORS_PER_REQUEST = MAX_SECTORS_DEFAULT
) (
	input  logic start,
	input  logic full,
	input  logic [START_ADDR_W-1:0] start_address,
	input  logic [ERASE_BYTES_W-1:0] erase_bytes,
	output logic push,
	output plan_ctl_t push_ctl,
	output logic [ADDRESS_BITS-1:0] push_addr
);

	logic accept;
	logic [FRONT_COUNT_W-1:0] count;
	logic [ADDRESS_BITS+START_ADDR_W-1:0] addr_ext;
	logic oversize;

	assign accept = start && !full;

	// Round the byte count up to whole sectors
	assign count = {1'b0, erase_bytes[ERASE_BYTES_W-1:SECTOR_SHIFT]}
		+ FRONT_COUNT_W'(|erase_bytes[SECTOR_SHIFT-1:0]);

	assign oversize = count > FRONT_COUNT_W'(MAX_SECTORS_PER_REQUEST);

	// Wrap the start address into the flash space
	assign addr_ext = {{ADDRESS_BITS{1'b0}}, start_address};
	assign push_addr = addr_ext[ADDRESS_BITS-1:0];

	// Drop empty requests, flag oversize ones
	assign push = accept && (count != '0);
	assign push_ctl.err = oversize;
	assign push_ctl.sectors = oversize ? '0 : count[COUNT_W-1:0];

endmodule

FILE: rtl/fecp_queue.sv
// Short request queue between the front and back ends.
module fecp_queue
	import fecp_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [WIDTH-1:0] push_data,
	input  logic pop,
	output logic [WIDTH-1:0] head_data,
	output logic not_empty,
	output logic full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign not_empty = count_q != '0;
	assign full = count_q == CNT_W'(DEPTH);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign head_data = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Hold the item data
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/fecp_back.sv
// Back end: walk one planned request and issue its erase commands.
module fecp_back
	import fecp_pkg::*;
#(
	parameter int ADDRESS_BITS = ADDRESS_BITS_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  plan_ctl_t head_ctl,
	input  logic [ADDRESS_BITS-1:0] head_addr,
	output logic pop,
	output logic result_strobe,
	output logic [1:0] erase_kind,
	output logic [OUT_ADDR_W-1:0] erase_address,
	output logic request_error,
	output logic last_command
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_RUN = 2'b10
	} back_state_t;

	back_state_t st_q;
	logic [ADDRESS_BITS-1:0] addr_q;
	logic [COUNT_W-1:0] remain_q;
	logic strobe_q;
	erase_kind_t kind_q;
	logic [OUT_ADDR_W-1:0] out_addr_q;
	logic err_q;
	logic last_q;

	erase_kind_t kind;
	logic [COUNT_W-1:0] step;
	logic [COUNT_W-1:0] remain_next;
	logic [ADDRESS_BITS-1:0] addr_next;
	logic [ADDRESS_BITS+OUT_ADDR_W-1:0] cur_ext;
	logic [ADDRESS_BITS+OUT_ADDR_W-1:0] head_ext;

	// Pick the largest erase that fits at the current address
	always_comb begin
		if (remain_q >= COUNT_W'(BLOCK_SECTORS) && addr_q[15:0] == '0) begin
			kind = KIND_BLOCK;
			step = COUNT_W'(BLOCK_SECTORS);
		end else if (remain_q >= COUNT_W'(HALF_SECTORS)
				&& addr_q[14:0] == '0) begin
			kind = KIND_HALF;
			step = COUNT_W'(HALF_SECTORS);
		end else begin
			kind = KIND_SECTOR;
			step = COUNT_W'(1);
		end
	end

	assign remain_next = remain_q - step;
	assign addr_next = addr_q + (ADDRESS_BITS'(step) << SECTOR_SHIFT);
	assign cur_ext = {{OUT_ADDR_W{1'b0}}, addr_q};
	assign head_ext = {{OUT_ADDR_W{1'b0}}, head_addr};

	assign pop = (st_q == BK_IDLE) && head_valid;

	// Sequence the run and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (st_q)
				BK_IDLE: begin
					if (head_valid) begin
						if (head_ctl.err) begin
							strobe_q <= 1'b1;
						end else begin
							st_q <= BK_RUN;
						end
					end
				end
				BK_RUN: begin
					strobe_q <= 1'b1;
					if (remain_next == '0) begin
						st_q <= BK_IDLE;
					end
				end
				default: begin
					st_q <= BK_IDLE;
				end
			endcase
		end
	end

	// Hold the walk position and the result fields
	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && head_valid) begin
			addr_q <= head_addr;
			remain_q <= head_ctl.sectors;
			kind_q <= KIND_SECTOR;
			out_addr_q <= head_ext[OUT_ADDR_W-1:0];
			err_q <= 1'b1;
			last_q <= 1'b1;
		end else if (st_q == BK_RUN) begin
			addr_q <= addr_next;
			remain_q <= remain_next;
			kind_q <= kind;
			out_addr_q <= cur_ext[OUT_ADDR_W-1:0];
			err_q <= 1'b0;
			last_q <= remain_next == '0;
		end
	end

	assign result_strobe = strobe_q;
	assign erase_kind = kind_q;
	assign erase_address = out_addr_q;
	assign request_error = err_q;
	assign last_command = last_q;

endmodule

FILE: rtl/fecp_checker.sv
// Port-level checks of the flash erase command planner, bound to the top level.
module fecp_checker
	import fecp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic result_strobe,
	input logic [1:0] erase_kind,
	input logic [OUT_ADDR_W-1:0] erase_address,
	input logic request_error,
	input logic last_command
);

	// An error result stands alone
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && request_error |-> last_command)
		else $error("error result without last_command");

	// An error result carries the sector code
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && request_error |-> erase_kind == KIND_SECTOR)
		else $error("error result with non-sector kind");

	// A run continues every cycle until its last command
	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_command |=> result_strobe)
		else $error("gap inside a command run");

	// A 64 KiB erase lands on a 64 KiB boundary
	a_block_align: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !request_error && erase_kind == KIND_BLOCK
		|-> erase_address[15:0] == '0)
		else $error("unaligned 64 KiB erase");

endmodule

bind flash_erase_command_planner fecp_checker u_fecp_checker (.*);
